>>> design/tdpb_pkg.sv
// shared types and constants of the tail drop packet buffer
// no dependencies

package tdpb_pkg;

    localparam int DEPTH_DEF  = 64;
    localparam int CAP_W      = 7;
    localparam int ARRIVAL_W  = 31;
    localparam int SERVICE_W  = 16;
    localparam int TIME_W     = 32;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_POP  = 3'b010,
        ST_FIN  = 3'b100
    } t_state;

    // result of the shared compare and add unit
    typedef struct packed {
        logic              a_ge_b;
        logic [TIME_W-1:0] hi;
        logic [TIME_W-1:0] sum_sat;
    } t_alu_res;

endpackage

>>> design/tdpb_alu.sv
// shared compare and saturating add unit of the tail drop packet buffer
// depends on tdpb_pkg

module tdpb_alu
    import tdpb_pkg::*;
(
    input  logic [TIME_W-1:0]    i_a,
    input  logic [TIME_W-1:0]    i_b,
    input  logic [SERVICE_W-1:0] i_c,
    output t_alu_res             o_res
);

    logic [TIME_W:0] sum;

    always_comb begin
        o_res.a_ge_b = (i_a >= i_b);
        o_res.hi     = o_res.a_ge_b ? i_a : i_b;
        sum          = {1'b0, o_res.hi} + {{(TIME_W+1-SERVICE_W){1'b0}}, i_c};
        // finish time saturates at all ones
        o_res.sum_sat = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
    end

endmodule

>>> design/tdpb_ram.sv
// finish time store: one write port, one read port with registered data
// depends on tdpb_pkg

module tdpb_ram
    import tdpb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [TIME_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output logic [TIME_W-1:0] o_rdata
);

    logic [TIME_W-1:0] r_mem [DEPTH];
    logic [TIME_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/tail_drop_packet_buffer.sv
// top level of the tail drop packet buffer: sequencer, queue pointers, output register
// depends on tdpb_pkg, tdpb_alu, tdpb_ram
//
// Single-server packet queue with tail drop. A request on the slave stream carries
// the arrival tick (tdata[30:0]) and the service ticks (tdata[46:31]). For each request the
// block first retires every queued finish time at or before the arrival, then admits
// the packet if occupancy is below min(capacity, DEPTH), else drops it. One result leaves
// on the master stream: the start tick in tdata, the dropped flag in tuser. Capacity is
// written through i_cfg_we / i_cfg_wdata, by the user only while the block is idle.
//
// The block itself does not enforce that rule. Timing: the sequencer retires one queued
// entry per cycle through the single read port of the finish time store. The finish state
// then registers the result and returns to idle, and o_s_tready rises at the same edge, so
// the next request can be taken in the following cycle. Each admitted packet is retired
// once, so on average at most one entry is retired per request. Reset clears head,
// occupancy and the output valid flag and sets capacity to 64; the store itself is not
// cleared. If the receiver stalls, the result is held in the output register; the next
// request is still taken and waits at its last step until the register frees.

module tail_drop_packet_buffer
    import tdpb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CAP_W-1:0]     i_cfg_wdata,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,   // arrival[30:0], service[46:31], pad
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,   // start[31:0]
    output logic                 o_m_tuser    // dropped[0]
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OW = $clog2(DEPTH + 1);
    localparam int XW = (OW > CAP_W) ? OW : CAP_W;
    localparam logic [OW:0]   DEPTH_S = (OW+1)'(DEPTH);
    localparam logic [AW-1:0] LAST_IX = AW'(DEPTH - 1);

    t_state                r_state, n_state;
    logic [AW-1:0]         r_head;
    logic [OW-1:0]         r_occ;
    logic [CAP_W-1:0]      r_cap;
    logic [ARRIVAL_W-1:0]  r_arrival;
    logic [SERVICE_W-1:0]  r_service;
    logic                  r_out_valid;
    logic                  r_out_dropped;
    logic [TIME_W-1:0]     r_out_start;

    logic [TIME_W-1:0]     rd_data;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         head_inc;
    logic [AW-1:0]         wr_idx;
    logic [AW-1:0]         tail_idx;
    logic [OW:0]           occ_sum;
    logic [TIME_W-1:0]     alu_b;
    t_alu_res              alu_res;
    logic                  s_take;
    logic                  pop;
    logic                  admit;
    logic                  fin_go;

    assign s_take   = i_s_tvalid && o_s_tready;
    assign head_inc = (r_head == LAST_IX) ? '0 : r_head + AW'(1);

    // slot after the newest entry, and the newest entry itself
    assign occ_sum  = {{(OW+1-AW){1'b0}}, r_head} + {1'b0, r_occ};
    assign wr_idx   = AW'((occ_sum >= DEPTH_S) ? occ_sum - DEPTH_S : occ_sum);
    assign tail_idx = (wr_idx == '0) ? LAST_IX : wr_idx - AW'(1);

    assign admit = (XW'(r_occ) < XW'(r_cap)) && (r_occ < OW'(DEPTH));

    // compare against the head while retiring, against the newest entry at the end, or zero if empty
    assign alu_b = (r_state == ST_FIN && r_occ == '0) ? '0 : rd_data;

    tdpb_alu u_alu (
        .i_a   ({1'b0, r_arrival}),
        .i_b   (alu_b),
        .i_c   (r_service),
        .o_res (alu_res)
    );

    assign pop    = (r_state == ST_POP) && (r_occ != '0) && alu_res.a_ge_b;
    assign fin_go = (r_state == ST_FIN) && (!r_out_valid || i_m_tready);

    always_comb begin
        unique case (r_state)
            ST_IDLE: rd_addr = r_head;
            ST_POP:  rd_addr = pop ? head_inc : tail_idx;
            ST_FIN:  rd_addr = tail_idx;
            default: rd_addr = r_head;
        endcase
    end

    tdpb_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (fin_go && admit),
        .i_waddr (wr_idx),
        .i_wdata (alu_res.sum_sat),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (s_take) n_state = ST_POP;
            ST_POP:  if (!pop) n_state = ST_FIN;
            ST_FIN:  if (fin_go) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_occ       <= '0;
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (pop) begin
                r_head <= head_inc;
                r_occ  <= r_occ - OW'(1);
            end else if (fin_go && admit) begin
                r_occ <= r_occ + OW'(1);
            end
            if (fin_go) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_take) begin
            r_arrival <= i_s_tdata[ARRIVAL_W-1:0];
            r_service <= i_s_tdata[ARRIVAL_W+SERVICE_W-1:ARRIVAL_W];
        end
        if (fin_go) begin
            r_out_dropped <= !admit;
            r_out_start   <= admit ? alu_res.hi : '0;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_start;
    assign o_m_tuser  = r_out_dropped;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OW'(DEPTH))
        else $error("occupancy above depth");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> r_occ == $past(r_occ) - OW'(1))
        else $error("retire did not lower occupancy");

    a_take_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_take |=> r_state == ST_POP)
        else $error("request taken but no retire step");

    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> o_m_tdata == '0)
        else $error("dropped packet with nonzero start");

    a_admit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin_go && admit) |-> (XW'(r_occ) < XW'(r_cap)))
        else $error("admitted packet beyond capacity");

endmodule

>>> dv/tb_tail_drop_packet_buffer.sv
// self-checking testbench for the tail drop packet buffer: stream driver, stream monitor
// and a built-in queue predictor; directed packets first, then random traffic phases
// depends on tdpb_pkg and tail_drop_packet_buffer

module tb_tail_drop_packet_buffer;
    import tdpb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH = DEPTH_DEF;
    localparam logic [CAP_W-1:0] CAP_FIELD_MAX = 7'd127;
    localparam longint ARRIVAL_MAX = 64'h7FFF_FFFF;

    typedef struct {
        logic [ARRIVAL_W-1:0] arrival;
        logic [SERVICE_W-1:0] service;
    } t_packet;

    typedef struct {
        logic              dropped;
        logic [TIME_W-1:0] start_tick;
    } t_departure;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CAP_W-1:0]     i_cfg_wdata = '0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic                 o_m_tuser;

    // shadow of the block's queue and capacity register
    logic [TIME_W-1:0] finish_ring [RING_DEPTH];
    logic [5:0]        ring_head = '0;
    int                ring_count = 0;
    logic [CAP_W-1:0]  cap_shadow = CAP_RESET;

    t_packet    feed_q [$];
    t_departure start_due [$];
    logic       s_fired = 1'b0;
    int         rx_hold_len = 0;
    int         n_queued = 0;
    int         n_sent = 0;
    int         n_checked = 0;
    int         n_dropped = 0;
    int         n_errors = 0;
    int         n_cap_writes = 0;
    longint     arr_now = 0;

    tail_drop_packet_buffer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    always #6 i_clk = ~i_clk;

    // retire finished packets, then admit or drop the new one
    function automatic t_departure admit_packet(input logic [ARRIVAL_W-1:0] arrival,
                                                input logic [SERVICE_W-1:0] service);
        t_departure res;
        int lim;
        logic [TIME_W-1:0] last_fin;
        logic [TIME_W:0] fin;
        lim = (cap_shadow > RING_DEPTH) ? RING_DEPTH : int'(cap_shadow);
        while (ring_count > 0 && {1'b0, arrival} >= finish_ring[ring_head]) begin
            ring_head = ring_head + 6'd1;
            ring_count--;
        end
        if (ring_count < lim) begin
            res.dropped = 1'b0;
            res.start_tick = {1'b0, arrival};
            if (ring_count > 0) begin
                last_fin = finish_ring[6'(ring_head + 6'(ring_count - 1))];
                if (last_fin > res.start_tick)
                    res.start_tick = last_fin;
            end
            fin = {1'b0, res.start_tick} + (TIME_W+1)'(service);
            if (fin[TIME_W])
                fin = {1'b0, {TIME_W{1'b1}}};
            finish_ring[6'(ring_head + 6'(ring_count))] = fin[TIME_W-1:0];
            ring_count++;
        end else begin
            res.dropped = 1'b1;
            res.start_tick = '0;
        end
        return res;
    endfunction

    // idle percentages for the first 150 packets sent, the next 150 and the rest
    function automatic int tx_idle_pct();
        return (n_sent < 150) ? 38 : (n_sent < 300) ? 58 : 0;
    endfunction

    function automatic int rx_idle_pct();
        return (n_sent < 150) ? 58 : (n_sent < 300) ? 38 : 0;
    endfunction

    // driver: request held until taken, new one offered at the falling edge
    always @(negedge i_clk) begin
        t_packet pkt;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || s_fired) begin
            if (feed_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct()) begin
                pkt = feed_q.pop_front();
                i_s_tdata <= {1'b0, pkt.service, pkt.arrival};
                i_s_tvalid <= 1'b1;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // receiver ready, with a long hold-off counted down here
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (rx_hold_len > 0) begin
            i_m_tready <= 1'b0;
            rx_hold_len--;
        end else begin
            i_m_tready <= ($urandom_range(0, 99) >= rx_idle_pct());
        end
    end

    // monitor: predict on accepted requests, compare accepted results
    always @(posedge i_clk) begin
        t_departure due;
        if (!i_rst_n) begin
            s_fired <= 1'b0;
        end else begin
            s_fired <= i_s_tvalid && o_s_tready;
            if (i_s_tvalid && o_s_tready) begin
                due = admit_packet(i_s_tdata[ARRIVAL_W-1:0],
                                   i_s_tdata[ARRIVAL_W+SERVICE_W-1:ARRIVAL_W]);
                start_due.insert(start_due.size(), due);
                n_sent++;
            end
            if (o_m_tvalid && i_m_tready) begin
                if (start_due.size() == 0) begin
                    $display("%0t result with nothing pending: dropped %0d start %0d",
                             $time, o_m_tuser, o_m_tdata);
                    n_errors++;
                end else begin
                    due = start_due.pop_front();
                    n_checked++;
                    if (due.dropped)
                        n_dropped++;
                    if (o_m_tuser !== due.dropped) begin
                        $display("%0t dropped: expected %0d, got %0d",
                                 $time, due.dropped, o_m_tuser);
                        n_errors++;
                    end
                    if (o_m_tdata !== due.start_tick) begin
                        $display("%0t start: expected %0d, got %0d",
                                 $time, due.start_tick, o_m_tdata);
                        n_errors++;
                    end
                end
            end
        end
    end

    task automatic push_packet(input longint arrival, input int service);
        t_packet pkt;
        pkt.arrival = arrival[ARRIVAL_W-1:0];
        pkt.service = service[SERVICE_W-1:0];
        feed_q.insert(feed_q.size(), pkt);
        n_queued++;
    endtask

    // every request answered and the sequencer back at rest
    task automatic wait_idle();
        @(negedge i_clk);
        while (n_sent != n_queued || start_due.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= cap;
        cap_shadow = cap;
        n_cap_writes++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic next_packet(input int gap_max, input int svc_max);
        int roll;
        int svc;
        longint arr;
        roll = $urandom_range(0, 99);
        svc = $urandom_range(0, svc_max);
        if (roll < 78) begin
            arr_now += $urandom_range(0, gap_max);
        end else if (roll < 86) begin
            // burst at the same tick
        end else if (roll < 91) begin
            // jump ahead by up to 1 << 24 ticks, which can empty the queue
            arr_now += $urandom_range(0, 1 << 24);
        end else if (roll < 96) begin
            svc = $urandom_range(0, 65535);
        end
        if (arr_now > ARRIVAL_MAX)
            arr_now = ARRIVAL_MAX;
        arr = arr_now;
        // occasional arrival earlier than the one before
        if (roll >= 96 && arr >= 1000)
            arr -= $urandom_range(1, 999);
        push_packet(arr, svc);
    endtask

    task automatic run_phase(input logic [CAP_W-1:0] cap, input int n, input int gap_max,
                             input int svc_max, input int jump_max, input int hold);
        wait_idle();
        write_capacity(cap);
        if (hold > 0) begin
            @(posedge i_clk);
            rx_hold_len = hold;
        end
        arr_now += $urandom_range(0, jump_max);
        repeat (n) next_packet(gap_max, svc_max);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset capacity: zero service, longest service, equal and earlier arrivals
        push_packet(0, 0);
        push_packet(0, 16'hFFFF);
        push_packet(0, 1);
        push_packet(0, 0);
        push_packet(40000, 16'h8000);
        push_packet(39999, 3);
        push_packet(65535, 16'h7FFF);
        push_packet(200000, 16'h5555);
        push_packet(200000, 16'h2AAA);

        // capacity zero drops everything, still retires
        wait_idle();
        write_capacity('0);
        push_packet(200001, 1);
        push_packet(300000, 2);
        push_packet(300000, 16'hFFFF);

        // capacity one
        wait_idle();
        write_capacity(7'd1);
        push_packet(300010, 100);
        push_packet(300020, 5);
        push_packet(300110, 7);
        push_packet(300110, 7);
        arr_now = 300110;

        // above depth, receiver stalled long so input backs up
        run_phase(CAP_FIELD_MAX, 80, 60, 300, 1 << 20, 300);
        // lowered below the occupancy left behind
        run_phase(7'd3, 60, 100, 200, 0, 0);
        run_phase(7'($urandom_range(2, 63)), 80, 150, 300, 1 << 29, 0);
        run_phase(CAP_RESET, 80, 80, 200, 1 << 29, 0);
        run_phase(CAP_FIELD_MAX, 80, 200, 200, 1 << 29, 0);

        // high arrivals, ending at the largest one
        wait_idle();
        write_capacity(7'($urandom_range(1, 10)));
        if (arr_now < 64'h4000_0000)
            arr_now = 64'h4000_0000;
        arr_now += $urandom_range(0, 32'h3F00_0000);
        repeat (70) next_packet(120, 250);
        push_packet(ARRIVAL_MAX, 16'hFFFF);

        wait_idle();
        repeat (80) @(negedge i_clk);
        $display("covered %0d packets over %0d capacity settings: %0d admitted, %0d dropped",
                 n_checked, n_cap_writes + 1, n_checked - n_dropped, n_dropped);
        if (n_errors == 0) begin
            $display("tail_drop_packet_buffer: match");
        end else begin
            $display("tail_drop_packet_buffer: mismatch");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("timeout with %0d results outstanding", start_due.size());
        $display("tail_drop_packet_buffer: mismatch");
        $finish;
    end

endmodule
